[rtl/core/rpeg_pkg.sv]
// Shared types, register indexes and the colour table for the RGBW pulse effect.
// No dependencies; imported by every module of the block.
package rpeg_pkg;

   localparam int LEVEL_W             = 8;
   localparam int TICK_COUNT_W        = 5;
   localparam int TABLE_ENTRIES       = 48;
   localparam int DEFAULT_TABLE_DEPTH = 48;
   localparam int CSR_INDEX_W         = 3;
   localparam int CSR_DATA_W          = 8;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_RANDOM_MODE = 3'd0,
      CSR_STEP_PERIOD = 3'd1,
      CSR_PHASE_FLOOR = 3'd2,
      CSR_FIXED_RED   = 3'd3,
      CSR_FIXED_GREEN = 3'd4,
      CSR_FIXED_BLUE  = 3'd5,
      CSR_FIXED_WHITE = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic               random_mode;
      logic [LEVEL_W-1:0] step_period;
      logic [LEVEL_W-1:0] phase_floor;
      logic [LEVEL_W-1:0] fixed_red;
      logic [LEVEL_W-1:0] fixed_green;
      logic [LEVEL_W-1:0] fixed_blue;
      logic [LEVEL_W-1:0] fixed_white;
   } cfg_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] red;
      logic [LEVEL_W-1:0] green;
      logic [LEVEL_W-1:0] blue;
   } rgb_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] red;
      logic [LEVEL_W-1:0] green;
      logic [LEVEL_W-1:0] blue;
      logic [LEVEL_W-1:0] white;
      logic               stepped;
   } level_set_type;

   localparam logic [LEVEL_W-1:0] RED_TABLE [0:TABLE_ENTRIES-1] = '{
      8'd0,   8'd255, 8'd144, 8'd216, 8'd0,   8'd255, 8'd127, 8'd255,
      8'd144, 8'd229, 8'd0,   8'd101, 8'd0,   8'd233, 8'd174, 8'd255,
      8'd0,   8'd153, 8'd233, 8'd242, 8'd0,   8'd233, 8'd29,  8'd101,
      8'd195, 8'd0,   8'd208, 8'd255, 8'd225, 8'd255, 8'd255, 8'd106,
      8'd0,   8'd0,   8'd148, 8'd144, 8'd0,   8'd255, 8'd229, 8'd4,
      8'd178, 8'd33,  8'd229, 8'd165, 8'd255, 8'd63,  8'd255, 8'd255
   };

   localparam logic [LEVEL_W-1:0] GREEN_TABLE [0:TABLE_ENTRIES-1] = '{
      8'd255, 8'd16,  8'd255, 8'd0,   8'd59,  8'd0,   8'd255, 8'd0,
      8'd0,   8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd238,
      8'd255, 8'd255, 8'd0,   8'd255, 8'd255, 8'd255, 8'd255, 8'd0,
      8'd0,   8'd255, 8'd255, 8'd0,   8'd255, 8'd136, 8'd106, 8'd255,
      8'd255, 8'd255, 8'd255, 8'd0,   8'd0,   8'd0,   8'd255, 8'd255,
      8'd0,   8'd0,   8'd255, 8'd255, 8'd0,   8'd255, 8'd0,   8'd0
   };

   localparam logic [LEVEL_W-1:0] BLUE_TABLE [0:TABLE_ENTRIES-1] = '{
      8'd225, 8'd0,   8'd0,   8'd255, 8'd255, 8'd131, 8'd0,   8'd29,
      8'd255, 8'd0,   8'd221, 8'd0,   8'd229, 8'd0,   8'd0,   8'd0,
      8'd169, 8'd0,   8'd255, 8'd0,   8'd63,  8'd0,   8'd0,   8'd255,
      8'd255, 8'd55,  8'd0,   8'd208, 8'd0,   8'd0,   8'd0,   8'd0,
      8'd131, 8'd187, 8'd0,   8'd255, 8'd255, 8'd238, 8'd0,   8'd0,
      8'd255, 8'd255, 8'd0,   8'd0,   8'd203, 8'd0,   8'd29,  8'd29
   };

   // entries past the end of the table read as black
   function automatic rgb_type table_color(input logic [7:0] idx);
      rgb_type c;
      c = '0;
      if (idx < 8'(TABLE_ENTRIES)) begin
         c.red   = RED_TABLE[idx[5:0]];
         c.green = GREEN_TABLE[idx[5:0]];
         c.blue  = BLUE_TABLE[idx[5:0]];
      end
      return c;
   endfunction

endpackage

[rtl/core/rpeg_csr.sv]
// Configuration register file for the RGBW pulse effect.
// Depends on rpeg_pkg for the register indexes and the cfg_type bundle.
module rpeg_csr
   import rpeg_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_RANDOM_MODE: cfg_in.random_mode = csr_wdata[0];
            CSR_STEP_PERIOD: cfg_in.step_period = csr_wdata;
            CSR_PHASE_FLOOR: cfg_in.phase_floor = csr_wdata;
            CSR_FIXED_RED:   cfg_in.fixed_red   = csr_wdata;
            CSR_FIXED_GREEN: cfg_in.fixed_green = csr_wdata;
            CSR_FIXED_BLUE:  cfg_in.fixed_blue  = csr_wdata;
            CSR_FIXED_WHITE: cfg_in.fixed_white = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/core/rpeg_engine.sv]
// Effect state and step logic: prescaler, triangle phase, colour table walk
// and the four level scalers. Depends on rpeg_pkg.
module rpeg_engine
   import rpeg_pkg::*;
#(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
)
(
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          advance,
   input  logic          tick,
   output level_set_type result
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);

   logic [TICK_COUNT_W-1:0] tick_count_ff, tick_count_in;
   logic [LEVEL_W-1:0]      phase_ff, phase_in;
   logic                    rising_ff, rising_in;
   logic [IDX_W-1:0]        table_index_ff, table_index_in;
   rgb_type                 random_color_ff, random_color_in;
   level_set_type           held_ff, held_in;

   logic [TICK_COUNT_W-1:0] step_limit;
   logic                    step;
   rgb_type                 col;

   // x / 255 for x up to 255 * 255
   function automatic logic [LEVEL_W-1:0] scale_level(input logic [LEVEL_W-1:0] c,
                                                      input logic [LEVEL_W-1:0] ph);
      logic [15:0] prod;
      logic [16:0] sum;
      prod = c * ph;
      sum  = 17'(prod) + 17'(prod[15:8]) + 17'd1;
      return sum[15:8];
   endfunction

   // p / 10 for 8-bit p
   function automatic logic [TICK_COUNT_W-1:0] div10(input logic [LEVEL_W-1:0] p);
      logic [15:0] prod;
      prod = 16'(p) * 16'd205;
      return prod[15:11];
   endfunction

   always_comb begin
      step_limit = div10(cfg.step_period);
      step       = tick && (tick_count_ff >= step_limit);

      col = cfg.random_mode ? random_color_ff
                            : rgb_type'({cfg.fixed_red, cfg.fixed_green, cfg.fixed_blue});

      tick_count_in   = tick_count_ff;
      phase_in        = phase_ff;
      rising_in       = rising_ff;
      table_index_in  = table_index_ff;
      random_color_in = random_color_ff;
      held_in         = held_ff;
      held_in.stepped = step;

      if (step) begin
         held_in.red   = scale_level(col.red, phase_ff);
         held_in.green = scale_level(col.green, phase_ff);
         held_in.blue  = scale_level(col.blue, phase_ff);
         held_in.white = scale_level(cfg.fixed_white, phase_ff);
         if (phase_ff == '1) begin
            rising_in = 1'b0;
         end
         if (phase_ff <= cfg.phase_floor) begin
            rising_in = 1'b1;
            if (cfg.random_mode) begin
               random_color_in = table_color(8'(table_index_ff));
               table_index_in  = (table_index_ff == IDX_LAST) ? '0 : table_index_ff + 1'b1;
            end
         end
         phase_in      = rising_in ? phase_ff + 1'b1 : phase_ff - 1'b1;
         tick_count_in = TICK_COUNT_W'(1);
      end else if (tick && (tick_count_ff != '1)) begin
         tick_count_in = tick_count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_count_ff   <= '0;
         phase_ff        <= '0;
         rising_ff       <= 1'b0;
         table_index_ff  <= '0;
         random_color_ff <= '0;
         held_ff         <= '0;
      end else if (advance) begin
         tick_count_ff   <= tick_count_in;
         phase_ff        <= phase_in;
         rising_ff       <= rising_in;
         table_index_ff  <= table_index_in;
         random_color_ff <= random_color_in;
         held_ff         <= held_in;
      end
   end

   assign result = held_in;

endmodule

[rtl/core/rgbw_pulse_effect_generator_unit.sv]
// Top level of the RGBW pulse effect: request register, effect engine, response register.
// Depends on rpeg_pkg, rpeg_csr and rpeg_engine.
//
//   channel  | direction | handshake                 | payload
//   req_     | in        | req_valid / req_ready     | req_tick
//   rsp_     | out       | rsp_valid / rsp_ready     | rsp_{red,green,blue,white}_level, rsp_stepped
//   csr_     | in        | csr_write_en              | csr_index, csr_wdata
//
// One request per cycle while the response is not stalled.
// The step is computed in one pass between the request and response registers.
// A stalled response holds the request register; req_ready drops only then.
// Reset is synchronous and clears all effect state and configuration.
module rgbw_pulse_effect_generator_unit
   import rpeg_pkg::*;
#(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_tick,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [LEVEL_W-1:0]     rsp_red_level,
   output logic [LEVEL_W-1:0]     rsp_green_level,
   output logic [LEVEL_W-1:0]     rsp_blue_level,
   output logic [LEVEL_W-1:0]     rsp_white_level,
   output logic                   rsp_stepped,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type       cfg;
   level_set_type result;
   level_set_type rsp_ff;

   logic req_valid_ff, req_valid_in;
   logic req_tick_ff;
   logic rsp_valid_ff, rsp_valid_in;
   logic advance;

   rpeg_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   rpeg_engine #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_engine (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .advance (advance),
      .tick    (req_tick_ff),
      .result  (result)
   );

   assign advance      = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready    = !req_valid_ff || advance;
   assign req_valid_in = (req_valid && req_ready) || (req_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_tick_ff <= req_tick;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_red_level   = rsp_ff.red;
   assign rsp_green_level = rsp_ff.green;
   assign rsp_blue_level  = rsp_ff.blue;
   assign rsp_white_level = rsp_ff.white;
   assign rsp_stepped     = rsp_ff.stepped;

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !req_valid_ff |-> req_ready)
      else $error("request register empty but req_ready low");

   a_advance_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("request moved on without a response");

   a_idle_no_step: assert property (@(posedge clock) disable iff (reset)
      (advance && !req_tick_ff) |=> !rsp_stepped)
      else $error("idle request reported a step");

endmodule

[bench/rpeg_effect_checker.sv]
`timescale 1ns / 100ps
// Pulse effect checker: watches the request, response and csr ports, predicts each response.
// Keeps its own copy of the registers, triangle state and colour table; depends on rpeg_pkg.
module rpeg_effect_checker
   import rpeg_pkg::*;
#(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic                   req_tick,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic [LEVEL_W-1:0]     rsp_red_level,
   input  logic [LEVEL_W-1:0]     rsp_green_level,
   input  logic [LEVEL_W-1:0]     rsp_blue_level,
   input  logic [LEVEL_W-1:0]     rsp_white_level,
   input  logic                   rsp_stepped,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     fail_count,
   output int                     pending
);

   localparam logic [7:0] SHADE_RED [0:47] = '{
      8'd0,   8'd255, 8'd144, 8'd216, 8'd0,   8'd255, 8'd127, 8'd255,
      8'd144, 8'd229, 8'd0,   8'd101, 8'd0,   8'd233, 8'd174, 8'd255,
      8'd0,   8'd153, 8'd233, 8'd242, 8'd0,   8'd233, 8'd29,  8'd101,
      8'd195, 8'd0,   8'd208, 8'd255, 8'd225, 8'd255, 8'd255, 8'd106,
      8'd0,   8'd0,   8'd148, 8'd144, 8'd0,   8'd255, 8'd229, 8'd4,
      8'd178, 8'd33,  8'd229, 8'd165, 8'd255, 8'd63,  8'd255, 8'd255
   };
   localparam logic [7:0] SHADE_GREEN [0:47] = '{
      8'd255, 8'd16,  8'd255, 8'd0,   8'd59,  8'd0,   8'd255, 8'd0,
      8'd0,   8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd238,
      8'd255, 8'd255, 8'd0,   8'd255, 8'd255, 8'd255, 8'd255, 8'd0,
      8'd0,   8'd255, 8'd255, 8'd0,   8'd255, 8'd136, 8'd106, 8'd255,
      8'd255, 8'd255, 8'd255, 8'd0,   8'd0,   8'd0,   8'd255, 8'd255,
      8'd0,   8'd0,   8'd255, 8'd255, 8'd0,   8'd255, 8'd0,   8'd0
   };
   localparam logic [7:0] SHADE_BLUE [0:47] = '{
      8'd225, 8'd0,   8'd0,   8'd255, 8'd255, 8'd131, 8'd0,   8'd29,
      8'd255, 8'd0,   8'd221, 8'd0,   8'd229, 8'd0,   8'd0,   8'd0,
      8'd169, 8'd0,   8'd255, 8'd0,   8'd63,  8'd0,   8'd0,   8'd255,
      8'd255, 8'd55,  8'd0,   8'd208, 8'd0,   8'd0,   8'd0,   8'd0,
      8'd131, 8'd187, 8'd0,   8'd255, 8'd255, 8'd238, 8'd0,   8'd0,
      8'd255, 8'd255, 8'd0,   8'd0,   8'd203, 8'd0,   8'd29,  8'd29
   };

   cfg_type       cfg;
   logic [4:0]    ticks_seen;
   logic [7:0]    phase;
   logic          rising;
   int unsigned   shade_idx;
   rgb_type       drawn;
   level_set_type held;
   level_set_type due_levels[$];
   level_set_type want;
   level_set_type got;

   function automatic logic [7:0] dim(input logic [7:0] colour, input logic [7:0] ph);
      logic [15:0] prod;
      prod = colour * ph;
      return 8'(prod / 16'd255);
   endfunction

   task automatic pulse_step();
      rgb_type src;
      if (cfg.random_mode) begin
         src = drawn;
      end else begin
         src.red   = cfg.fixed_red;
         src.green = cfg.fixed_green;
         src.blue  = cfg.fixed_blue;
      end
      held.red   = dim(src.red, phase);
      held.green = dim(src.green, phase);
      held.blue  = dim(src.blue, phase);
      held.white = dim(cfg.fixed_white, phase);
      if (phase == 8'd255)
         rising = 1'b0;
      if (phase <= cfg.phase_floor) begin
         if (cfg.random_mode) begin
            drawn = '0;
            if (shade_idx < TABLE_ENTRIES) begin
               drawn.red   = SHADE_RED[shade_idx];
               drawn.green = SHADE_GREEN[shade_idx];
               drawn.blue  = SHADE_BLUE[shade_idx];
            end
            shade_idx++;
            if (shade_idx >= TABLE_DEPTH)
               shade_idx = 0;
         end
         rising = 1'b1;
      end
      phase = rising ? phase + 8'd1 : phase - 8'd1;
   endtask

   task automatic advance_tick(input logic tick, output level_set_type res);
      logic did_step;
      did_step = 1'b0;
      if (tick) begin
         if (ticks_seen >= 5'(cfg.step_period / 8'd10)) begin
            pulse_step();
            ticks_seen = '0;
            did_step   = 1'b1;
         end
         if (ticks_seen < 5'd31)
            ticks_seen++;
      end
      res         = held;
      res.stepped = did_step;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg        = '0;
         ticks_seen = '0;
         phase      = '0;
         rising     = 1'b0;
         shade_idx  = 0;
         drawn      = '0;
         held       = '0;
         fail_count = 0;
         due_levels.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.red     = rsp_red_level;
            got.green   = rsp_green_level;
            got.blue    = rsp_blue_level;
            got.white   = rsp_white_level;
            got.stepped = rsp_stepped;
            if (due_levels.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: response with no request due: r=%0d g=%0d b=%0d w=%0d s=%0b",
                           $time, got.red, got.green, got.blue, got.white, got.stepped);
            end else begin
               want = due_levels.pop_front();
               if (got.red !== want.red || got.green !== want.green ||
                   got.blue !== want.blue || got.white !== want.white ||
                   got.stepped !== want.stepped) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $write("%0t: mismatch: exp r=%0d g=%0d b=%0d w=%0d s=%0b,",
                            $time, want.red, want.green, want.blue, want.white, want.stepped);
                     $display(" got r=%0d g=%0d b=%0d w=%0d s=%0b",
                              got.red, got.green, got.blue, got.white, got.stepped);
                  end
               end
            end
         end
         if (csr_write_en) begin
            case (csr_index)
               CSR_RANDOM_MODE: cfg.random_mode = csr_wdata[0];
               CSR_STEP_PERIOD: cfg.step_period = csr_wdata;
               CSR_PHASE_FLOOR: cfg.phase_floor = csr_wdata;
               CSR_FIXED_RED:   cfg.fixed_red   = csr_wdata;
               CSR_FIXED_GREEN: cfg.fixed_green = csr_wdata;
               CSR_FIXED_BLUE:  cfg.fixed_blue  = csr_wdata;
               CSR_FIXED_WHITE: cfg.fixed_white = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            advance_tick(req_tick, want);
            due_levels.push_back(want);
         end
      end
      pending = due_levels.size();
   end

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// Testbench top for the RGBW pulse effect unit: clock, reset, csr writes, tick requests, idling.
// Depends on rpeg_pkg, the unit under test and rpeg_effect_checker, which checks every response.
module tb;
   import rpeg_pkg::*;

   localparam int STALL_LIMIT = 4000;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASES      = 12;
   localparam int PHASE_ITEMS = 150;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic                   req_tick;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [LEVEL_W-1:0]     rsp_red_level;
   logic [LEVEL_W-1:0]     rsp_green_level;
   logic [LEVEL_W-1:0]     rsp_blue_level;
   logic [LEVEL_W-1:0]     rsp_white_level;
   logic                   rsp_stepped;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   int                     fails;
   int                     pending;
   int                     idle_cycles;
   bit                     steady;
   bit                     hold_rx;

   rgbw_pulse_effect_generator_unit u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_tick        (req_tick),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_red_level   (rsp_red_level),
      .rsp_green_level (rsp_green_level),
      .rsp_blue_level  (rsp_blue_level),
      .rsp_white_level (rsp_white_level),
      .rsp_stepped     (rsp_stepped),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   rpeg_effect_checker u_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_tick        (req_tick),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_red_level   (rsp_red_level),
      .rsp_green_level (rsp_green_level),
      .rsp_blue_level  (rsp_blue_level),
      .rsp_white_level (rsp_white_level),
      .rsp_stepped     (rsp_stepped),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fail_count      (fails),
      .pending         (pending)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // mostly short, a few long
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return $urandom_range(1, 3);
      else if (r < 94)
         return $urandom_range(4, 10);
      else
         return $urandom_range(20, 60);
   endfunction

   function automatic int sender_gap();
      if (steady || $urandom_range(0, 1) == 0)
         return 0;
      return idle_len();
   endfunction

   function automatic logic [7:0] pick_level();
      case ($urandom_range(0, 3))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic offer_tick(input logic tick, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_tick  <= tick;
      do @(posedge clock); while (!req_ready);
   endtask

   // stop offering until every response is back
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic put_reg(input csr_index_type idx, input logic [7:0] val);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(posedge clock);
   endtask

   task automatic write_config(input logic rm, input logic [7:0] per, input logic [7:0] flr,
                               input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                               input logic [7:0] w);
      put_reg(CSR_RANDOM_MODE, {7'd0, rm});
      put_reg(CSR_STEP_PERIOD, per);
      put_reg(CSR_PHASE_FLOOR, flr);
      put_reg(CSR_FIXED_RED, r);
      put_reg(CSR_FIXED_GREEN, g);
      put_reg(CSR_FIXED_BLUE, b);
      put_reg(CSR_FIXED_WHITE, w);
      csr_write_en <= 1'b0;
   endtask

   initial begin
      int          n;
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         if (hold_rx) begin
            hold_rx = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (steady || $urandom_range(0, 99) < 60) begin
            rsp_ready <= 1'b1;
            n = steady ? 1 : $urandom_range(1, 12);
            repeat (n) @(posedge clock);
         end else begin
            rsp_ready <= 1'b0;
            repeat (idle_len()) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_en)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   initial begin
      logic [7:0] per;
      logic [7:0] flr;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_tick     = 1'b0;
      csr_write_en = 1'b0;
      csr_index    = CSR_RANDOM_MODE;
      csr_wdata    = '0;
      steady       = 1'b0;
      hold_rx      = 1'b0;
      idle_cycles  = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // every tick steps, full colours, idle ticks in between
      write_config(1'b0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255);
      offer_tick(1'b0, 0);
      repeat (3) offer_tick(1'b1, sender_gap());
      offer_tick(1'b0, 0);
      offer_tick(1'b1, 0);
      // table colours from black, floor at the top so the phase only rises
      settle();
      write_config(1'b1, 8'd9, 8'd255, 8'd0, 8'd0, 8'd0, 8'd128);
      repeat (6) offer_tick(1'b1, sender_gap());
      // slowest prescale
      settle();
      write_config(1'b1, 8'd255, 8'd254, 8'd255, 8'd255, 8'd255, 8'd0);
      repeat (8) offer_tick(1'b1, sender_gap());

      for (int ph = 0; ph < PHASES; ph++) begin
         settle();
         per = ($urandom_range(0, 5) == 0) ? pick_level() : 8'($urandom_range(0, 39));
         case ($urandom_range(0, 3))
            0: flr = 8'd0;
            1: flr = 8'd255;
            2: flr = 8'($urandom_range(200, 254));
            default: flr = 8'($urandom_range(0, 255));
         endcase
         write_config(1'($urandom_range(0, 1)), per, flr, pick_level(), pick_level(),
                      pick_level(), pick_level());
         steady = (ph == 2);
         if (ph == 1)
            hold_rx = 1'b1;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i == PHASE_ITEMS / 2 && (ph == 0 || $urandom_range(0, 3) == 0))
               settle();
            offer_tick($urandom_range(0, 9) != 0, (ph == 1) ? 0 : sender_gap());
         end
         steady = 1'b0;
      end
      settle();

      if (fails == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule

[files.f]
rtl/core/rpeg_pkg.sv
rtl/core/rpeg_csr.sv
rtl/core/rpeg_engine.sv
rtl/core/rgbw_pulse_effect_generator_unit.sv
bench/rpeg_effect_checker.sv
bench/tb.sv
